// File: src/mtld_pkg.sv
package mtld_pkg;

  // Fixed widths of the node ids and of the distance values on the ports.
  localparam int NODE_W = 32;
  localparam int DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_DEPTH_DEF = 255;
  localparam int NODE_BITS_DEF = 32;

  // Reset value of the no-path distance register.
  localparam logic [DATA_W-1:0] NO_PATH_RESET = '1;

  // One position of both labels, as held in the input register.
  typedef struct packed {
    logic              a_present;
    logic [NODE_W-1:0] a_node;
    logic              b_present;
    logic [NODE_W-1:0] b_node;
    logic              tree_end;
    logic              query_end;
  } item_t;

  // What the tree tracker hands to the best-distance stage for one item.
  typedef struct packed {
    logic              close;
    logic              qend;
    logic              hit;
    logic              ovf;
    logic [DATA_W-1:0] tree_dist;
    logic [NODE_W-1:0] anc;
  } tree_close_t;

endpackage

// File: src/mtld_in_reg.sv
module mtld_in_reg
  import mtld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  out_free,
  output item_t item,
  output logic  go
);

  logic valid;

  // An item that ends a query can only move on when the result register is free.
  assign go       = valid && (!item.query_end || out_free);
  assign in_stall = valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

// File: src/mtld_tree.sv
module mtld_tree
  import mtld_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int NODE_BITS = NODE_BITS_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  item_t       item,
  output tree_close_t tc
);

  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEPTH);

  logic             still_matching;
  logic [CNT_W-1:0] prefix_count;
  logic [CNT_W-1:0] length_a;
  logic [CNT_W-1:0] length_b;
  logic [CMP_W-1:0] tree_ancestor;

  logic             match;
  logic [CNT_W-1:0] prefix_count_next;
  logic [CNT_W-1:0] length_a_next;
  logic [CNT_W-1:0] length_b_next;
  logic [CMP_W-1:0] tree_ancestor_next;
  logic [CNT_W:0]   dist_sum;

  always_comb begin
    match = still_matching && item.a_present && item.b_present &&
            (item.a_node[CMP_W-1:0] == item.b_node[CMP_W-1:0]);

    length_a_next = length_a;
    if (item.a_present && (length_a < CNT_MAX)) begin
      length_a_next = length_a + CNT_W'(1);
    end
    length_b_next = length_b;
    if (item.b_present && (length_b < CNT_MAX)) begin
      length_b_next = length_b + CNT_W'(1);
    end

    prefix_count_next  = prefix_count;
    tree_ancestor_next = tree_ancestor;
    if (match) begin
      if (prefix_count < CNT_MAX) begin
        prefix_count_next = prefix_count + CNT_W'(1);
      end
      tree_ancestor_next = item.a_node[CMP_W-1:0];
    end

    // The prefix never exceeds either length, so this cannot go negative.
    dist_sum = {1'b0, length_a_next} + {1'b0, length_b_next} -
               {prefix_count_next, 1'b0};

    tc.close     = item.tree_end || item.query_end;
    tc.qend      = item.query_end;
    tc.hit       = (prefix_count_next != '0);
    tc.ovf       = (item.a_present && (length_a >= CNT_MAX)) ||
                   (item.b_present && (length_b >= CNT_MAX));
    tc.tree_dist = DATA_W'(dist_sum);
    tc.anc       = NODE_W'(tree_ancestor_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_matching <= 1'b1;
      prefix_count   <= '0;
      length_a       <= '0;
      length_b       <= '0;
      tree_ancestor  <= '0;
    end else if (go) begin
      if (tc.close) begin
        still_matching <= 1'b1;
        prefix_count   <= '0;
        length_a       <= '0;
        length_b       <= '0;
        tree_ancestor  <= '0;
      end else begin
        still_matching <= match;
        prefix_count   <= prefix_count_next;
        length_a       <= length_a_next;
        length_b       <= length_b_next;
        tree_ancestor  <= tree_ancestor_next;
      end
    end
  end

endmodule

// File: src/mtld_best.sv
module mtld_best
  import mtld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              go,
  input  tree_close_t       tc,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] distance,
  output logic [NODE_W-1:0] ancestor_node,
  output logic              ancestor_valid,
  output logic              depth_overflow
);

  logic [DATA_W-1:0] no_path_distance;
  logic [DATA_W-1:0] best_distance;
  logic [NODE_W-1:0] best_ancestor;
  logic              best_found;
  logic              overflow_seen;

  logic [DATA_W-1:0] bound;
  logic              take;
  logic [DATA_W-1:0] best_distance_next;
  logic [NODE_W-1:0] best_ancestor_next;
  logic              best_found_next;
  logic              overflow_seen_next;

  // Until a tree is taken the bound is the live no-path register, so a
  // register write is seen without copying it into the running best.
  always_comb begin
    bound              = best_found ? best_distance : no_path_distance;
    take               = tc.close && tc.hit && (tc.tree_dist < bound);
    best_distance_next = take ? tc.tree_dist : bound;
    best_ancestor_next = take ? tc.anc : best_ancestor;
    best_found_next    = best_found || take;
    overflow_seen_next = overflow_seen || tc.ovf;
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_path_distance <= NO_PATH_RESET;
    end else if (cfg_wr_en) begin
      no_path_distance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found    <= 1'b0;
      overflow_seen <= 1'b0;
      best_ancestor <= '0;
    end else if (go) begin
      if (tc.qend) begin
        best_found    <= 1'b0;
        overflow_seen <= 1'b0;
        best_ancestor <= '0;
      end else begin
        best_found    <= best_found_next;
        overflow_seen <= overflow_seen_next;
        best_ancestor <= best_ancestor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      best_distance <= best_distance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && tc.qend) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && tc.qend) begin
      distance       <= best_distance_next;
      ancestor_node  <= best_found_next ? best_ancestor_next : '0;
      ancestor_valid <= best_found_next;
      depth_overflow <= overflow_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(go && tc.qend))
    else $error("result register overwritten while stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (go && tc.qend) |=> out_valid)
    else $error("query end did not produce a result");

  a_anc_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ancestor_valid) |-> (ancestor_node == '0))
    else $error("ancestor nonzero without a qualifying tree");

  a_found_below_bound: assert property (@(posedge clk) disable iff (rst)
    (go && take) |=> (best_found || out_valid))
    else $error("taken tree lost before query end");
`endif

endmodule

// File: src/multi_tree_label_distance_top.sv
// Multi-tree label distance estimator.
// Input channel (in_valid / in_stall): one beat per label position. Each beat
// carries the element of both root-to-node labels at that depth, tree_end on
// the last position of a tree, and query_end on the last position of the last
// tree of a query. Output channel (out_valid / out_stall): one beat per query,
// with the smallest label distance over all trees that share a root prefix,
// that tree's lowest common ancestor, and an overflow flag for over-long labels.
// cfg_wr_en / cfg_wr_data write the no-path distance; write it between queries.
// Throughput is one input beat per cycle while no query_end beat waits for a
// stalled result register. A beat is captured in the input register, and from
// there the tree counters and the running best are updated from it in a single
// pass; the result of a query_end beat is loaded into the output register in
// that same update, which waits until the output register is free.
// When the receiver stalls, the result register holds its beat. Positions that
// do not end a query keep flowing; the next query_end beat waits in the input
// register, and in_stall is raised only then.
// Synchronous reset clears all tree and query state, empties both registers
// and sets the no-path distance to all ones.
module multi_tree_label_distance_top
  import mtld_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int NODE_BITS = NODE_BITS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              a_present,
  input  logic [NODE_W-1:0] a_node,
  input  logic              b_present,
  input  logic [NODE_W-1:0] b_node,
  input  logic              tree_end,
  input  logic              query_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] distance,
  output logic [NODE_W-1:0] ancestor_node,
  output logic              ancestor_valid,
  output logic              depth_overflow
);

  item_t       in_item;
  item_t       item;
  logic        go;
  logic        out_free;
  tree_close_t tc;

  always_comb begin
    in_item.a_present = a_present;
    in_item.a_node    = a_node;
    in_item.b_present = b_present;
    in_item.b_node    = b_node;
    in_item.tree_end  = tree_end;
    in_item.query_end = query_end;
  end

  // Input register: holds a query_end beat until the result register is free; other beats pass on.
  mtld_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .item     (item),
    .go       (go)
  );

  // Per-tree prefix and length counters; closes a tree on tree_end or query_end.
  mtld_tree #(
    .MAX_DEPTH (MAX_DEPTH),
    .NODE_BITS (NODE_BITS)
  ) u_tree (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (item),
    .tc   (tc)
  );

  // Running best over the trees of a query and the result register.
  mtld_best u_best (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .go             (go),
    .tc             (tc),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distance       (distance),
    .ancestor_node  (ancestor_node),
    .ancestor_valid (ancestor_valid),
    .depth_overflow (depth_overflow)
  );

endmodule
